/* hdl/rms_normalization_core_macros.svh */
// ----------------------------------------------------------------------------
// rms normalization core assertion macros
// shared concurrent assertion forms, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef RMS_NORMALIZATION_CORE_MACROS_SVH
`define RMS_NORMALIZATION_CORE_MACROS_SVH
`ifndef SYNTH
`define RN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rmsn_pkg.sv */
// ----------------------------------------------------------------------------
// rmsn_pkg
// request and result types of the rms normalization core
// ----------------------------------------------------------------------------
`default_nettype none
package rmsn_pkg;
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;
    localparam int EPS_W = 25;
    localparam logic [EPS_W-1:0] EPS_RESET = 25'd17;

    typedef struct packed {
        logic               action;
        logic signed [15:0] sample;
        logic signed [15:0] gain;
        logic               row_end;
    } rmsn_in_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               final_res;
        logic               status;
    } rmsn_out_t;
endpackage
`default_nettype wire

/* hdl/rms_normalization_core.sv */
// ----------------------------------------------------------------------------
// rms_normalization_core
// fixed point rms normalization of one row, row stored in block memory
// ----------------------------------------------------------------------------
// channel   direction  handshake       payload
// in        sink       valid / stall   rmsn_in_t
// out       source     valid / stall   rmsn_out_t
// cfg       sink       valid / ready   epsilon, 25 bits
//
// push: the sum is updated in the push state. pull: the result is valid after memory
// read, product, scale and round; the next request is taken the cycle after the
// result leaves. row close: the shared one-bit-per-cycle unit divides for the mean,
// then for the reciprocal, then takes the root, all during the closing push.
// reset clears control and restores epsilon; the row memory is not cleared.
// a waiting result blocks new requests until taken.
`default_nettype none
`include "rms_normalization_core_macros.svh"
module rms_normalization_core
    import rmsn_pkg::*;
#(
    parameter int ROW_LENGTH_MAX = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire rmsn_in_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rmsn_out_t                 out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [EPS_W-1:0]     cfg_data
);
    localparam int AW = (ROW_LENGTH_MAX > 1) ? $clog2(ROW_LENGTH_MAX) : 1;
    localparam int CW = $clog2(ROW_LENGTH_MAX + 1);
    // sum of squares: count times 2^30 at most
    localparam int SW = 30 + CW;

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH, S_DIVM, S_DIVR, S_SQRT, S_RD, S_MUL, S_RND, S_OUT
    } state_t;

    state_t state_reg;
    logic [EPS_W-1:0] eps_reg;
    logic [SW-1:0] sum_reg;
    logic [CW-1:0] cnt_reg, rdi_reg;
    logic ready_reg;
    logic [31:0] inv_reg;
    logic [31:0] sq_reg;
    logic [15:0] smag_reg;
    logic close_reg;
    rmsn_out_t out_reg;

    // shared serial unit registers
    logic [63:0] q_reg;
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [6:0]  step_reg;
    logic [33:0] root_reg;

    // row memories
    logic [15:0] smem [ROW_LENGTH_MAX];
    logic [15:0] gmem [ROW_LENGTH_MAX];
    logic [15:0] s_rd_reg, g_rd_reg;
    logic        wr_en;
    logic [AW-1:0] wr_addr;

    logic [47:0] prod_reg;
    logic        neg_reg;
    logic [63:0] mag_reg;

    assign cfg_ready = (state_reg == S_IDLE) && !out_valid;
    assign in_stall  = !((state_reg == S_IDLE) && !out_valid);
    assign out_data  = out_reg;

    logic acc;
    assign acc = in_valid && !in_stall;
    logic cnt_full;
    assign cnt_full = (ready_reg ? CW'(0) : cnt_reg) >= CW'(ROW_LENGTH_MAX);
    assign wr_en   = acc && in_data.action == ACT_PUSH && !cnt_full;
    assign wr_addr = ready_reg ? AW'(0) : cnt_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            smem[wr_addr] <= in_data.sample;
            gmem[wr_addr] <= in_data.gain;
        end
        s_rd_reg <= smem[rdi_reg[AW-1:0]];
        g_rd_reg <= gmem[rdi_reg[AW-1:0]];
    end

    // restoring long division / root step helpers
    logic [64:0] div_trial;
    assign div_trial = {rem_reg[63:0], q_reg[63]} - {1'b0, den_reg};
    logic [63:0] div_q_next;
    logic [63:0] div_r_next;
    assign div_q_next = div_trial[64] ? {q_reg[62:0], 1'b0} : {q_reg[62:0], 1'b1};
    assign div_r_next = div_trial[64] ? {rem_reg[62:0], q_reg[63]} : div_trial[63:0];
    logic [65:0] sq_rem_next;
    logic [65:0] sq_trial;
    assign sq_rem_next = {rem_reg[63:0], q_reg[63:62]};
    assign sq_trial = sq_rem_next - {30'd0, root_reg, 2'b01};

    logic [15:0] s_abs, g_abs;
    assign s_abs = s_rd_reg[15] ? 16'(-s_rd_reg) : s_rd_reg;
    assign g_abs = g_rd_reg[15] ? 16'(-g_rd_reg) : g_rd_reg;
    logic [15:0] in_abs;
    assign in_abs = in_data.sample[15] ? 16'(-in_data.sample) : in_data.sample;

    logic [31:0] rnd;
    assign rnd = 32'((mag_reg + 64'h8000_0000) >> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eps_reg   <= EPS_RESET;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            rdi_reg   <= '0;
            ready_reg <= 1'b0;
            inv_reg   <= '0;
            out_valid <= 1'b0;
            close_reg <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
                eps_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (acc && in_data.action == ACT_PUSH)
                    begin
                        if (ready_reg)
                        begin
                            sum_reg   <= '0;
                            cnt_reg   <= '0;
                            rdi_reg   <= '0;
                            ready_reg <= 1'b0;
                        end
                        smag_reg  <= in_abs;
                        close_reg <= in_data.row_end;
                        sq_reg    <= cnt_full ? 32'd0 : 32'd1;
                        state_reg <= S_PUSH;
                    end
                    else if (acc)
                    begin
                        if (!ready_reg || rdi_reg >= cnt_reg)
                        begin
                            out_reg   <= '{value: '0, final_res: 1'b0, status: 1'b1};
                            out_valid <= 1'b1;
                        end
                        else
                            state_reg <= S_RD;
                    end
                end
                S_PUSH:
                begin
                    if (sq_reg[0])
                    begin
                        sum_reg <= sum_reg + SW'(smag_reg * smag_reg);
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (close_reg)
                    begin
                        // mean = sum / count
                        q_reg     <= 64'(sum_reg + (sq_reg[0] ? SW'(smag_reg * smag_reg)
                                                              : SW'(0)));
                        rem_reg   <= '0;
                        den_reg   <= 64'(cnt_reg + (sq_reg[0] ? CW'(1) : CW'(0)));
                        step_reg  <= '0;
                        state_reg <= S_DIVM;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_DIVM:
                begin
                    if (step_reg == 7'd63)
                    begin
                        // m = mean + eps; q = 2^64 / m via dividend 2^64 - 1 adjusted below
                        den_reg   <= div_q_next + 64'(eps_reg);
                        q_reg     <= '1;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIVR;
                    end
                    else
                    begin
                        rem_reg  <= {1'b0, div_r_next};
                        q_reg    <= div_q_next;
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_DIVR:
                begin
                    if (step_reg == 7'd63)
                    begin
                        // exact 2^64 / m: bump when remainder equals m - 1
                        if (div_r_next == den_reg - 64'd1)
                            q_reg <= div_q_next + 64'd1;
                        else
                            q_reg <= div_q_next;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= (den_reg <= 64'd1) ? S_IDLE : S_SQRT;
                        if (den_reg <= 64'd1)
                        begin
                            inv_reg   <= '1;
                            rdi_reg   <= '0;
                            ready_reg <= cnt_reg != '0;
                        end
                    end
                    else
                    begin
                        rem_reg  <= {1'b0, div_r_next};
                        q_reg    <= div_q_next;
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_SQRT:
                begin
                    // one root bit per cycle
                    if (!sq_trial[65])
                    begin
                        rem_reg  <= 65'(sq_trial);
                        root_reg <= {root_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= 65'(sq_rem_next);
                        root_reg <= {root_reg[32:0], 1'b0};
                    end
                    q_reg    <= {q_reg[61:0], 2'b00};
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'd31)
                    begin
                        inv_reg   <= !sq_trial[65] ? {root_reg[30:0], 1'b1}
                                                   : {root_reg[30:0], 1'b0};
                        rdi_reg   <= '0;
                        ready_reg <= cnt_reg != '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                    state_reg <= S_MUL;
                S_MUL:
                begin
                    prod_reg  <= 48'(s_abs * g_abs);
                    neg_reg   <= s_rd_reg[15] ^ g_rd_reg[15];
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    mag_reg   <= 64'(prod_reg[31:0] * inv_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (neg_reg)
                        out_reg.value <= (rnd > 32'd32768) ? 16'sh8000 : 16'(32'd65536 - rnd);
                    else
                        out_reg.value <= (rnd > 32'd32767) ? 16'sh7fff : 16'(rnd);
                    out_reg.final_res <= (rdi_reg + CW'(1) == cnt_reg);
                    out_reg.status    <= 1'b0;
                    out_valid         <= 1'b1;
                    if (rdi_reg + CW'(1) == cnt_reg)
                    begin
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        rdi_reg   <= '0;
                        ready_reg <= 1'b0;
                    end
                    else
                        rdi_reg <= rdi_reg + CW'(1);
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `RN_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `RN_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(ROW_LENGTH_MAX))
    `RN_ASSERT_NEXT(a_out_from_round, clk, rst_n, state_reg == S_OUT, out_valid)
    `RN_ASSERT_IMPL(a_read_in_row, clk, rst_n, state_reg == S_RD, ready_reg && rdi_reg < cnt_reg)
endmodule
`default_nettype wire
